// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge of i_clk outside reset.
`define LSA_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising edge of i_clk outside reset.
`define LSA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hw/rtl/lsa_pkg.sv -----
`default_nettype none
package lsa_pkg;

    localparam logic [1:0] REQ_APPEND_A = 2'd0;
    localparam logic [1:0] REQ_APPEND_B = 2'd1;
    localparam logic [1:0] REQ_ALIGN    = 2'd2;

    localparam logic [1:0] PTR_DIAG = 2'd0;
    localparam logic [1:0] PTR_UP   = 2'd1;
    localparam logic [1:0] PTR_LEFT = 2'd2;
    localparam logic [1:0] PTR_ZERO = 2'd3;

    localparam logic [1:0] REG_MATCH    = 2'd0;
    localparam logic [1:0] REG_MISMATCH = 2'd1;
    localparam logic [1:0] REG_GAP      = 2'd2;

    localparam logic [3:0]        MATCH_RESET    = 4'd1;
    localparam logic signed [4:0] MISMATCH_RESET = -5'sd4;
    localparam logic signed [4:0] GAP_RESET      = -5'sd4;

    typedef struct packed {
        logic       clr;
        logic       shift;
        logic       load_b;
        logic       col_en;
        logic [7:0] b_sym;
    } t_cell_ctl;

endpackage
`default_nettype wire

// ----- hw/rtl/lsa_cell.sv -----
`default_nettype none
module lsa_cell
    import lsa_pkg::*;
#(
    parameter int SW = 12,
    parameter int RA = 7,
    parameter int AW = 6,
    parameter int DEPTH = 64
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cell_ctl            i_ctl,
    input  wire logic [3:0]           i_match,
    input  wire logic signed [4:0]    i_mism,
    input  wire logic signed [4:0]    i_gap,
    input  wire logic                 i_vld,
    input  wire logic [7:0]           i_sym,
    input  wire logic [RA-1:0]        i_row,
    input  wire logic signed [SW-1:0] i_h,
    input  wire logic signed [SW-1:0] i_hdiag,
    output logic                      o_vld,
    output logic [7:0]                o_sym,
    output logic [RA-1:0]             o_row,
    output logic signed [SW-1:0]      o_h,
    output logic signed [SW-1:0]      o_hdiag,
    input  wire logic signed [SW-1:0] i_scan_bv,
    input  wire logic [RA-1:0]        i_scan_bi,
    output logic signed [SW-1:0]      o_bv,
    output logic [RA-1:0]             o_bi,
    input  wire logic [AW-1:0]        i_rd_addr,
    output logic [1:0]                o_ptr
);

    logic [7:0]           r_b_sym;
    logic signed [SW-1:0] r_h;
    logic signed [SW-1:0] r_bv;
    logic [RA-1:0]        r_bi;
    logic                 r_vld;
    logic [7:0]           r_sym;
    logic [RA-1:0]        r_row;
    logic signed [SW-1:0] r_hout;
    logic signed [SW-1:0] r_hdiag;
    logic [1:0]           r_ptr_q;
    logic [1:0]           r_mem [DEPTH];

    logic signed [SW-1:0] w_sim;
    logic signed [SW-1:0] w_up;
    logic signed [SW-1:0] w_left;
    logic signed [SW-1:0] w_v;
    logic [1:0]           w_p;
    logic [RA-1:0]        w_row_m1;

    always_comb begin
        w_sim = (i_sym == r_b_sym) ? SW'($signed({1'b0, i_match})) : SW'(i_mism);
        w_up = r_h + SW'(i_gap);
        w_left = i_h + SW'(i_gap);
        w_v = i_hdiag + w_sim;
        w_p = PTR_DIAG;
        if (w_up > w_v) begin
            w_v = w_up;
            w_p = PTR_UP;
        end
        if (w_left > w_v) begin
            w_v = w_left;
            w_p = PTR_LEFT;
        end
        if (w_v < 0) begin
            w_v = '0;
            w_p = PTR_ZERO;
        end
        w_row_m1 = i_row - RA'(1);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_b) begin
            r_b_sym <= i_ctl.b_sym;
        end
        r_sym <= i_sym;
        r_row <= i_row;
        r_hout <= w_v;
        r_hdiag <= r_h;
        if (i_vld) begin
            r_mem[w_row_m1[AW-1:0]] <= w_p;
        end
        r_ptr_q <= r_mem[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clr) begin
            r_h <= '0;
            r_bv <= '0;
            r_bi <= '0;
            r_vld <= 1'b0;
        end else begin
            r_vld <= i_vld;
            if (i_vld) begin
                r_h <= w_v;
            end
            if (i_ctl.shift) begin
                r_bv <= i_scan_bv;
                r_bi <= i_scan_bi;
            end else if (i_vld && i_ctl.col_en && (w_v > r_bv)) begin
                r_bv <= w_v;
                r_bi <= i_row;
            end
        end
    end

    assign o_vld = r_vld;
    assign o_sym = r_sym;
    assign o_row = r_row;
    assign o_h = r_hout;
    assign o_hdiag = r_hdiag;
    assign o_bv = r_bv;
    assign o_bi = r_bi;
    assign o_ptr = r_ptr_q;

endmodule
`default_nettype wire

// ----- hw/rtl/local_sequence_alignment_top.sv -----
`default_nettype none
// Smith-Waterman local aligner with a linear gap score. Symbol requests for A and B are
// taken one per cycle while no align is running. An align request runs a systolic row of
// MAX_LEN_B cells, one per symbol of B, while the rows of A stream through it: the fill
// runs first, then the per-cell best scores shift out, and the traceback then follows the
// pointers with a registered pointer read from the cells at each step. An align may also
// wait for a result still held in the output register. Symbol requests are stalled until
// the align result is loaded into the output register. Past MAX_LEN_A symbols of A or
// MAX_LEN_B symbols of B are dropped and reported through overflow; after each align both
// sequences are empty again.
module local_sequence_alignment_top
    import lsa_pkg::*;
#(
    parameter int MAX_LEN_A = 64,
    parameter int MAX_LEN_B = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [7:0]  i_symbol,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [6:0]       o_start_a,
    output logic [6:0]       o_length_a,
    output logic [6:0]       o_start_b,
    output logic [6:0]       o_length_b,
    output logic [9:0]       o_best_score,
    output logic             o_overflow
);

    localparam int SW = $clog2(15 * (MAX_LEN_A + MAX_LEN_B) + 1) + 1;
    localparam int SX = (SW > 11) ? SW : 11;
    localparam int RA = $clog2(MAX_LEN_A + 1);
    localparam int CB = $clog2(MAX_LEN_B + 1);
    localparam int AW = (MAX_LEN_A > 1) ? $clog2(MAX_LEN_A) : 1;
    localparam int BW = (MAX_LEN_B > 1) ? $clog2(MAX_LEN_B) : 1;
    localparam int RX = (RA > 7) ? RA : 7;
    localparam int CX = (CB > 7) ? CB : 7;
    localparam int CW = $clog2(MAX_LEN_A + MAX_LEN_B + 4);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_FILL = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_TBA  = 3'd3;
    localparam logic [2:0] ST_TBD  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [3:0]           r_match;
    logic signed [4:0]    r_mism;
    logic signed [4:0]    r_gap;
    logic [RA-1:0]        r_len_a;
    logic [CB-1:0]        r_len_b;
    logic                 r_drop;
    logic [7:0]           r_a_mem [MAX_LEN_A];
    logic [7:0]           r_a_q;
    logic                 r_inj_vld;
    logic [RA-1:0]        r_inj_row;
    logic [CW-1:0]        r_cnt;
    logic signed [SW-1:0] r_bv;
    logic [RA-1:0]        r_bi;
    logic [CB-1:0]        r_bj;
    logic [RA-1:0]        r_ci;
    logic [CB-1:0]        r_cj;
    logic                 r_ovld;
    logic [6:0]           r_start_a;
    logic [6:0]           r_length_a;
    logic [6:0]           r_start_b;
    logic [6:0]           r_length_b;
    logic [9:0]           r_best;
    logic                 r_ovf;

    logic                 w_acc;
    logic                 w_cfg_wr;
    logic                 w_shift;
    logic                 w_issue;
    logic                 w_out_ld;
    logic                 w_take;
    logic [RA-1:0]        w_ci_m1;
    logic [CB-1:0]        w_cj_m1;
    logic [1:0]           w_p;
    logic [RA-1:0]        w_ni;
    logic [CB-1:0]        w_nj;
    logic                 w_move;
    logic [CB-1:0]        w_col;
    logic [RX-1:0]        w_sa;
    logic [RX-1:0]        w_la;
    logic [CX-1:0]        w_sb;
    logic [CX-1:0]        w_lb;
    logic signed [SX-1:0] w_bvx;

    t_cell_ctl            w_ctl   [MAX_LEN_B];
    logic                 w_vld   [MAX_LEN_B+1];
    logic [7:0]           w_sym   [MAX_LEN_B+1];
    logic [RA-1:0]        w_row   [MAX_LEN_B+1];
    logic signed [SW-1:0] w_h     [MAX_LEN_B+1];
    logic signed [SW-1:0] w_hdiag [MAX_LEN_B+1];
    logic signed [SW-1:0] w_sbv   [MAX_LEN_B+1];
    logic [RA-1:0]        w_sbi   [MAX_LEN_B+1];
    logic [1:0]           w_ptr   [MAX_LEN_B];

    assign pready = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_acc = i_in_valid && !o_in_stall;
    assign w_shift = (r_state == ST_SCAN);
    assign w_issue = (r_state == ST_FILL) && (CW'(r_len_a) > r_cnt);
    assign w_out_ld = (r_state == ST_OUT) && (!r_ovld || !i_out_stall);
    assign w_take = (w_sbv[0] > r_bv) || ((w_sbv[0] == r_bv) && (w_sbi[0] < r_bi));

    always_comb begin
        unique case (paddr[3:2])
            REG_MATCH:    prdata = {28'd0, r_match};
            REG_MISMATCH: prdata = 32'($signed(r_mism));
            REG_GAP:      prdata = 32'($signed(r_gap));
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= MATCH_RESET;
            r_mism <= MISMATCH_RESET;
            r_gap <= GAP_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3:2])
                REG_MATCH:    r_match <= pwdata[3:0];
                REG_MISMATCH: r_mism <= pwdata[4:0];
                REG_GAP:      r_gap <= pwdata[4:0];
                default:      ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc && (i_req_type == REQ_APPEND_A) && (r_len_a < RA'(MAX_LEN_A))) begin
            r_a_mem[r_len_a[AW-1:0]] <= i_symbol;
        end
        r_a_q <= r_a_mem[r_cnt[AW-1:0]];
    end

    assign w_vld[0] = r_inj_vld;
    assign w_sym[0] = r_a_q;
    assign w_row[0] = r_inj_row;
    assign w_h[0] = '0;
    assign w_hdiag[0] = '0;
    assign w_sbv[MAX_LEN_B] = '0;
    assign w_sbi[MAX_LEN_B] = '0;

    assign w_ci_m1 = r_ci - RA'(1);
    assign w_cj_m1 = r_cj - CB'(1);

    for (genvar k = 0; k < MAX_LEN_B; k++) begin : g_cell
        always_comb begin
            w_ctl[k].clr = w_acc && (i_req_type == REQ_ALIGN);
            w_ctl[k].shift = w_shift;
            w_ctl[k].load_b = w_acc && (i_req_type == REQ_APPEND_B) && (r_len_b == CB'(k));
            w_ctl[k].col_en = (r_len_b > CB'(k));
            w_ctl[k].b_sym = i_symbol;
        end

        lsa_cell #(
            .SW(SW),
            .RA(RA),
            .AW(AW),
            .DEPTH(MAX_LEN_A)
        ) u_cell (
            .i_clk(i_clk),
            .i_rst_n(i_rst_n),
            .i_ctl(w_ctl[k]),
            .i_match(r_match),
            .i_mism(r_mism),
            .i_gap(r_gap),
            .i_vld(w_vld[k]),
            .i_sym(w_sym[k]),
            .i_row(w_row[k]),
            .i_h(w_h[k]),
            .i_hdiag(w_hdiag[k]),
            .o_vld(w_vld[k+1]),
            .o_sym(w_sym[k+1]),
            .o_row(w_row[k+1]),
            .o_h(w_h[k+1]),
            .o_hdiag(w_hdiag[k+1]),
            .i_scan_bv(w_sbv[k+1]),
            .i_scan_bi(w_sbi[k+1]),
            .o_bv(w_sbv[k]),
            .o_bi(w_sbi[k]),
            .i_rd_addr(w_ci_m1[AW-1:0]),
            .o_ptr(w_ptr[k])
        );
    end

    always_comb begin
        w_p = w_ptr[w_cj_m1[BW-1:0]];
        w_ni = ((w_p == PTR_DIAG) || (w_p == PTR_UP)) ? w_ci_m1 : r_ci;
        w_nj = ((w_p == PTR_DIAG) || (w_p == PTR_LEFT)) ? w_cj_m1 : r_cj;
        w_move = (w_ni != '0) && (w_nj != '0) && (w_p != PTR_ZERO);
        w_col = r_cnt[CB-1:0] + CB'(1);
        w_sa = RX'(r_ci);
        w_la = RX'(r_bi - r_ci);
        w_sb = CX'(r_cj);
        w_lb = CX'(r_bj - r_cj);
        w_bvx = SX'(r_bv);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_acc && (i_req_type == REQ_ALIGN)) begin
                    n_state = ST_FILL;
                end
            end
            ST_FILL: begin
                if (r_cnt == CW'(r_len_a) + CW'(MAX_LEN_B + 1)) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (r_cnt == CW'(MAX_LEN_B - 1)) begin
                    n_state = ST_TBA;
                end
            end
            ST_TBA: begin
                n_state = (r_bv == '0) ? ST_OUT : ST_TBD;
            end
            ST_TBD: begin
                n_state = w_move ? ST_TBA : ST_OUT;
            end
            ST_OUT: begin
                if (w_out_ld) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_len_a <= '0;
            r_len_b <= '0;
            r_drop <= 1'b0;
            r_inj_vld <= 1'b0;
            r_ovld <= 1'b0;
            r_cnt <= '0;
        end else begin
            r_state <= n_state;
            r_inj_vld <= w_issue;
            if (w_out_ld) begin
                r_ovld <= 1'b1;
            end else if (o_out_valid && !i_out_stall) begin
                r_ovld <= 1'b0;
            end
            if (w_acc && (i_req_type == REQ_APPEND_A)) begin
                if (r_len_a < RA'(MAX_LEN_A)) begin
                    r_len_a <= r_len_a + RA'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (w_acc && (i_req_type == REQ_APPEND_B)) begin
                if (r_len_b < CB'(MAX_LEN_B)) begin
                    r_len_b <= r_len_b + CB'(1);
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (r_state != n_state) begin
                r_cnt <= '0;
            end else if ((r_state == ST_FILL) || (r_state == ST_SCAN)) begin
                r_cnt <= r_cnt + CW'(1);
            end
            if (w_out_ld) begin
                r_len_a <= '0;
                r_len_b <= '0;
                r_drop <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_inj_row <= r_cnt[RA-1:0] + RA'(1);
        if (w_acc && (i_req_type == REQ_ALIGN)) begin
            r_bv <= '0;
            r_bi <= '0;
            r_bj <= '0;
        end else if (w_shift) begin
            if (w_take) begin
                r_bv <= w_sbv[0];
                r_bi <= w_sbi[0];
                r_bj <= w_col;
            end
        end
        if (r_state == ST_SCAN) begin
            if (w_take) begin
                r_ci <= w_sbi[0];
                r_cj <= w_col;
            end else begin
                r_ci <= r_bi;
                r_cj <= r_bj;
            end
        end else if ((r_state == ST_TBD) && w_move) begin
            r_ci <= w_ni;
            r_cj <= w_nj;
        end
        if (w_out_ld) begin
            r_start_a <= w_sa[6:0];
            r_length_a <= w_la[6:0];
            r_start_b <= w_sb[6:0];
            r_length_b <= w_lb[6:0];
            r_best <= (w_bvx > SX'(1023)) ? 10'd1023 : w_bvx[9:0];
            r_ovf <= r_drop;
        end
    end

    assign o_out_valid = r_ovld;
    assign o_start_a = r_start_a;
    assign o_length_a = r_length_a;
    assign o_start_b = r_start_b;
    assign o_length_b = r_length_b;
    assign o_best_score = r_best;
    assign o_overflow = r_ovf;

endmodule
`default_nettype wire

// ----- hw/rtl/lsa_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module lsa_checker
    import lsa_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_in_valid,
    input wire logic       o_in_stall,
    input wire logic [1:0] i_req_type,
    input wire logic       o_out_valid,
    input wire logic       i_out_stall,
    input wire logic [6:0] o_start_a,
    input wire logic [6:0] o_length_a,
    input wire logic [6:0] o_start_b,
    input wire logic [6:0] o_length_b,
    input wire logic [9:0] o_best_score
);

    logic w_align_acc;
    logic w_span_zero;

    assign w_align_acc = i_in_valid && !o_in_stall && (i_req_type == REQ_ALIGN);
    assign w_span_zero = (o_start_a == 7'd0) && (o_length_a == 7'd0)
        && (o_start_b == 7'd0) && (o_length_b == 7'd0);

    `LSA_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid)
    `LSA_ASSERT_NEXT(a_align_busy, w_align_acc, o_in_stall)
    `LSA_ASSERT_NOW(a_zero_span, o_out_valid && (o_best_score == 10'd0), w_span_zero)

endmodule

bind local_sequence_alignment_top lsa_checker u_lsa_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .i_in_valid(i_in_valid),
    .o_in_stall(o_in_stall),
    .i_req_type(i_req_type),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_start_a(o_start_a),
    .o_length_a(o_length_a),
    .o_start_b(o_start_b),
    .o_length_b(o_length_b),
    .o_best_score(o_best_score)
);
`default_nettype wire

// ----- verif/local_sequence_alignment_top_test.sv -----
`default_nettype none
module local_sequence_alignment_top_test;
    import lsa_pkg::*;

    localparam int MAXA = 64;
    localparam int MAXB = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam logic [1:0] REQ_NONE = 2'd3;

    typedef struct packed {
        logic [6:0] start_a;
        logic [6:0] length_a;
        logic [6:0] start_b;
        logic [6:0] length_b;
        logic [9:0] best_score;
        logic       overflow;
    } t_span;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_req_type = '0;
    logic [7:0]  i_symbol = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [6:0]  o_start_a, o_length_a, o_start_b, o_length_b;
    logic [9:0]  o_best_score;
    logic        o_overflow;

    local_sequence_alignment_top dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    class align_scoreboard;
        logic [7:0] seq_a[MAXA];
        logic [7:0] seq_b[MAXB];
        int n_a, n_b;
        bit dropped;
        int match_pts, mismatch_pts, gap_pts;
        t_span pending[$];
        int errors;

        function void clear_all();
            n_a = 0;
            n_b = 0;
            dropped = 0;
            match_pts = 1;
            mismatch_pts = -4;
            gap_pts = -4;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] v);
            if (idx == REG_MATCH) match_pts = int'(v[3:0]);
            else if (idx == REG_MISMATCH) mismatch_pts = int'($signed(v[4:0]));
            else if (idx == REG_GAP) gap_pts = int'($signed(v[4:0]));
        endfunction

        function t_span align_spans();
            logic [1:0] ptr[MAXA][MAXB];
            int row[MAXB+1];
            int diag, up, v, bi, bj, bv, ci, cj, ni, nj;
            logic [1:0] p;
            t_span r;
            for (int j = 0; j <= MAXB; j++) row[j] = 0;
            bi = 0; bj = 0; bv = 0;
            for (int i = 1; i <= n_a; i++) begin
                diag = 0;
                for (int j = 1; j <= n_b; j++) begin
                    up = row[j];
                    v = diag + ((seq_a[i-1] == seq_b[j-1]) ? match_pts : mismatch_pts);
                    p = PTR_DIAG;
                    if (up + gap_pts > v) begin v = up + gap_pts; p = PTR_UP; end
                    if (row[j-1] + gap_pts > v) begin v = row[j-1] + gap_pts; p = PTR_LEFT; end
                    if (0 > v) begin v = 0; p = PTR_ZERO; end
                    ptr[i-1][j-1] = p;
                    diag = up;
                    row[j] = v;
                    if (v > bv) begin bv = v; bi = i; bj = j; end
                end
            end
            ci = bi; cj = bj;
            forever begin
                p = (ci >= 1 && cj >= 1) ? ptr[ci-1][cj-1] : PTR_ZERO;
                ni = (p == PTR_DIAG || p == PTR_UP) ? ci - 1 : ci;
                nj = (p == PTR_DIAG || p == PTR_LEFT) ? cj - 1 : cj;
                if (ni == 0 || nj == 0 || (ni == ci && nj == cj)) break;
                ci = ni; cj = nj;
            end
            r.start_a = 7'(ci);
            r.length_a = 7'(bi - ci);
            r.start_b = 7'(cj);
            r.length_b = 7'(bj - cj);
            r.best_score = (bv > 1023) ? 10'd1023 : bv[9:0];
            r.overflow = dropped;
            return r;
        endfunction

        function void note_request(logic [1:0] rt, logic [7:0] sym);
            if (rt == REQ_APPEND_A) begin
                if (n_a < MAXA) begin seq_a[n_a] = sym; n_a++; end
                else dropped = 1;
            end else if (rt == REQ_APPEND_B) begin
                if (n_b < MAXB) begin seq_b[n_b] = sym; n_b++; end
                else dropped = 1;
            end else if (rt == REQ_ALIGN) begin
                pending.push_back(align_spans());
                n_a = 0; n_b = 0; dropped = 0;
            end
        endfunction

        function void check_result(t_span got);
            t_span want;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.start_a !== want.start_a)
                $display("%0t: start_a expected %0d actual %0d", $time, want.start_a, got.start_a);
            if (got.length_a !== want.length_a)
                $display("%0t: length_a expected %0d actual %0d", $time, want.length_a,
                    got.length_a);
            if (got.start_b !== want.start_b)
                $display("%0t: start_b expected %0d actual %0d", $time, want.start_b, got.start_b);
            if (got.length_b !== want.length_b)
                $display("%0t: length_b expected %0d actual %0d", $time, want.length_b,
                    got.length_b);
            if (got.best_score !== want.best_score)
                $display("%0t: best_score expected %0d actual %0d", $time, want.best_score,
                    got.best_score);
            if (got.overflow !== want.overflow)
                $display("%0t: overflow expected %0d actual %0d", $time, want.overflow,
                    got.overflow);
            if (got !== want) errors++;
        endfunction
    endclass

    align_scoreboard sb;
    int idle_pct = 23;
    bit hold_sink = 0;
    int quiet_cycles = 0;
    int results_seen = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (o_out_valid && !i_out_stall) begin
                sb.check_result({o_start_a, o_length_a, o_start_b, o_length_b,
                    o_best_score, o_overflow});
                results_seen <= results_seen + 1;
            end
            if (i_in_valid && !o_in_stall) sb.note_request(i_req_type, i_symbol);
            i_out_stall <= hold_sink || ($urandom_range(99) < idle_pct);
        end
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] v);
        @(posedge i_clk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
        paddr <= {idx, 2'b00}; pwdata <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.set_reg(idx, v);
    endtask

    task automatic send(logic [1:0] rt, logic [7:0] sym);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= rt;
        i_symbol <= sym;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (500) @(posedge i_clk);
    endtask

    task automatic send_pair(int la, int lb, int alpha);
        for (int k = 0; k < la; k++) send(REQ_APPEND_A, 8'($urandom_range(alpha - 1)));
        for (int k = 0; k < lb; k++) send(REQ_APPEND_B, 8'($urandom_range(alpha - 1)));
        send(REQ_ALIGN, 8'($urandom));
    endtask

    initial begin
        int cfg_sets[5][3];
        sb = new();
        sb.clear_all();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send(REQ_ALIGN, 8'h00);
        send(REQ_APPEND_A, 8'hff);
        send(REQ_ALIGN, 8'hff);
        send(REQ_APPEND_A, 8'h00);
        send(REQ_APPEND_B, 8'h00);
        send(REQ_NONE, 8'h55);
        send(REQ_ALIGN, 8'h00);
        send(REQ_APPEND_A, 8'hff); send(REQ_APPEND_A, 8'h0f);
        send(REQ_APPEND_B, 8'h0f); send(REQ_APPEND_B, 8'hff);
        send(REQ_ALIGN, 8'h00);
        send(REQ_APPEND_A, 8'h12); send(REQ_APPEND_B, 8'h34);
        send(REQ_ALIGN, 8'h00);
        drain();
        for (int k = 0; k < MAXA + 2; k++) send(REQ_APPEND_A, 8'h7);
        for (int k = 0; k < MAXB + 2; k++) send(REQ_APPEND_B, 8'h7);
        send(REQ_ALIGN, 8'h00);
        drain();

        cfg_sets = '{'{15, 0, 0}, '{0, 16, 16}, '{15, 16, 0}, '{7, 2, 1}, '{1, 28, 28}};
        for (int c = 0; c < 5; c++) begin
            write_reg(REG_MATCH, cfg_sets[c][0]);
            write_reg(REG_MISMATCH, cfg_sets[c][1]);
            write_reg(REG_GAP, cfg_sets[c][2]);
            send_pair(MAXA, MAXB, 2);
            send_pair($urandom_range(1, 8), $urandom_range(1, 8), 4);
            drain();
        end

        write_reg(REG_MATCH, 32'd4);
        write_reg(REG_MISMATCH, 32'h1d);
        write_reg(REG_GAP, 32'h1e);
        idle_pct = 0;
        for (int k = 0; k < 10; k++) send_pair($urandom_range(0, 10), $urandom_range(0, 10), 4);
        idle_pct = 23;
        hold_sink = 1;
        fork
            begin
                repeat (3000) @(posedge i_clk);
                hold_sink = 0;
            end
            for (int k = 0; k < 6; k++) send_pair(3, 3, 2);
        join
        drain();

        for (int c = 0; c < 4; c++) begin
            write_reg(REG_MATCH, $urandom_range(15));
            write_reg(REG_MISMATCH, $urandom_range(31));
            write_reg(REG_GAP, $urandom_range(31));
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(9) == 0)
                    send(2'($urandom_range(3)), 8'($urandom));
                else if ($urandom_range(19) == 0)
                    send_pair($urandom_range(0, 70), $urandom_range(0, 70), 256);
                else
                    send_pair($urandom_range(0, 8), $urandom_range(0, 8),
                        $urandom_range(0, 1) ? 4 : 256);
            end
            drain();
        end

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
